### rtl/core/sorted_list_insert_delete_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted list block
// Shared concurrent assertion wrappers, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DELETE_MACROS_SVH
`define SORTED_LIST_INSERT_DELETE_MACROS_SVH

// Check that cond holds at every clock edge out of reset.
`define SLI_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that ante implies cons in the same cycle.
`define SLI_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that ante implies cons in the next cycle.
`define SLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg
// Types and constants shared by the sorted list insert/delete block.
// ----------------------------------------------------------------------------
package sli_pkg;

    // Default table depth
    localparam int CAPACITY_DEF = 16;

    // Value width and result count width
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // Operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    // Status codes
    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // Input beat
    typedef struct packed {
        logic                      func;
        logic signed [VALUE_W-1:0] value;
    } t_in;

    // Output beat
    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        logic               status;
    } t_out;

endpackage

### rtl/core/sorted_list_insert_delete.sv
// Sorted list insert/delete. The block keeps up to CAPACITY signed 32-bit
// values in ascending order in a single-port-read table RAM. Each input beat
// is an insert or a delete-all-equal; each yields one output beat with the
// new entry count and a status bit (set when an insert hits a full table and
// is dropped). An insert into a table of n entries (n above zero) at
// position p walks the entries from the top down, one per cycle; a delete
// walks all n entries from the bottom up; an insert into an empty table, a
// full-table insert or an empty-table delete needs no walk. The single read
// port of the table RAM sets the pace at one entry per cycle. One item is in
// work at a time; the output register holds a finished result while the next
// beat is taken.
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Bounded ascending table with in-order insert and delete-all-equal.
// ----------------------------------------------------------------------------
`include "sorted_list_insert_delete_macros.svh"

module sorted_list_insert_delete #(
    parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sli_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output sli_pkg::t_out o_data
);

    import sli_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,
        S_PUT  = 5'b00100,
        S_DEL  = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    // Map an internal count onto the 5-bit result field
    function automatic logic [COUNT_W-1:0] to_count(input logic [CW-1:0] c);
        logic [CW+COUNT_W-1:0] wide;
        wide = {{COUNT_W{1'b0}}, c};
        return wide[COUNT_W-1:0];
    endfunction

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_occ, n_occ;
    logic [AW-1:0]              r_cur, n_cur;
    logic [CW-1:0]              r_keep, n_keep;
    logic signed [VALUE_W-1:0]  r_val, n_val;
    t_out                       r_res, n_res;
    logic                       r_out_valid, n_out_valid;
    t_out                       r_out, n_out;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [VALUE_W-1:0]         ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [VALUE_W-1:0]         ram_rdata;

    logic signed [VALUE_W-1:0]  w_entry;
    logic [CW-1:0]              w_occ_dec_full;
    logic [AW-1:0]              w_occ_dec;
    logic [CW-1:0]              w_occ_inc;
    logic [AW-1:0]              w_cur_inc;
    logic [AW-1:0]              w_cur_dec;
    logic                       w_keep_it;
    logic [CW-1:0]              w_keep_nx;

    // Table storage
    sli_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Index arithmetic
    assign w_entry        = $signed(ram_rdata);
    assign w_occ_dec_full = r_occ - CW'(1);
    assign w_occ_dec      = w_occ_dec_full[AW-1:0];
    assign w_occ_inc      = r_occ + CW'(1);
    assign w_cur_inc      = r_cur + AW'(1);
    assign w_cur_dec      = r_cur - AW'(1);
    assign w_keep_it      = (w_entry != r_val);
    assign w_keep_nx      = w_keep_it ? r_keep + CW'(1) : r_keep;

    // Sequencer: walk the table one entry per cycle
    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_cur       = r_cur;
        n_keep      = r_keep;
        n_val       = r_val;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = w_cur_inc;
        ram_wdata   = r_val;
        ram_re      = 1'b0;
        ram_raddr   = w_cur_dec;

        // Drop the output beat once taken
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_val = i_data.value;
                    if (i_data.func == FUNC_INSERT) begin
                        if (r_occ >= CW'(CAPACITY)) begin
                            n_res   = '{entry_count: to_count(r_occ), status: ST_FULL};
                            n_state = S_RESP;
                        end else if (r_occ == '0) begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = i_data.value;
                            n_occ     = w_occ_inc;
                            n_res     = '{entry_count: to_count(w_occ_inc), status: ST_DONE};
                            n_state   = S_RESP;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = w_occ_dec;
                            n_cur     = w_occ_dec;
                            n_state   = S_INS;
                        end
                    end else begin
                        if (r_occ == '0) begin
                            n_res   = '{entry_count: to_count(r_occ), status: ST_DONE};
                            n_state = S_RESP;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_cur     = '0;
                            n_keep    = '0;
                            n_state   = S_DEL;
                        end
                    end
                end
            end

            // Shift larger-or-equal entries up by one, top down
            S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = w_cur_inc;
                if (w_entry < r_val) begin
                    ram_wdata = r_val;
                    n_occ     = w_occ_inc;
                    n_res     = '{entry_count: to_count(w_occ_inc), status: ST_DONE};
                    n_state   = S_RESP;
                end else begin
                    ram_wdata = ram_rdata;
                    if (r_cur == '0) begin
                        n_state = S_PUT;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = w_cur_dec;
                        n_cur     = w_cur_dec;
                    end
                end
            end

            // Place the new value at the bottom slot
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = r_val;
                n_occ     = w_occ_inc;
                n_res     = '{entry_count: to_count(w_occ_inc), status: ST_DONE};
                n_state   = S_RESP;
            end

            // Compact: copy non-matching entries down, bottom up
            S_DEL: begin
                if (w_keep_it) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_keep[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                n_keep = w_keep_nx;
                if (r_cur == w_occ_dec) begin
                    n_occ   = w_keep_nx;
                    n_res   = '{entry_count: to_count(w_keep_nx), status: ST_DONE};
                    n_state = S_RESP;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = w_cur_inc;
                    n_cur     = w_cur_inc;
                end
            end

            // Hand the result to the output register when it is free
            S_RESP: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_keep <= n_keep;
        r_val  <= n_val;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Checks
    `SLI_ASSERT_ALWAYS(a_occ_bound, r_occ <= CW'(CAPACITY), "occupancy above capacity")
    `SLI_ASSERT_IMPLY(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr,
        "table read and write hit the same entry")
    `SLI_ASSERT_IMPLY(a_keep_behind, r_state == S_DEL, r_keep <= CW'(r_cur),
        "compaction write index ahead of read index")
    `SLI_ASSERT_IMPLY(a_full_status, r_state == S_RESP && r_res.status == ST_FULL,
        r_occ == CW'(CAPACITY), "drop flagged on a table that is not full")
    `SLI_ASSERT_NEXT(a_put_grows, r_state == S_PUT, r_occ == $past(w_occ_inc),
        "bottom insert did not grow the table")

endmodule

### rtl/core/sli_ram.sv
// ----------------------------------------------------------------------------
// sli_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### bench/sorted_list_insert_delete_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_tb
// Self-checking bench for the sorted list block. Inserts and deletes go in
// through random source gaps and sink stalls. A scoreboard keeps its own
// ordered copy of the table and checks the count and status of every
// result beat against it.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_tb;
    import sli_pkg::*;

    localparam int DEPTH        = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1325;
    localparam int TAIL_CYCLES  = 4 * DEPTH;
    localparam int CYCLE_LIMIT  = 400000;

    // Shadow table plus the queue of results still owed by the block
    class sorted_table_scoreboard;
        logic signed [VALUE_W-1:0] held_values[$];
        t_out                      owed_results[$];
        int errors        = 0;
        int inserts       = 0;
        int dropped       = 0;
        int deletes       = 0;
        int missed        = 0;
        int multi_removed = 0;
        int peak          = 0;

        function int held();
            return held_values.size();
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function logic signed [VALUE_W-1:0] pick_held();
            return held_values[$urandom_range(0, held_values.size() - 1)];
        endfunction

        // Apply an accepted input beat to the shadow table, queue its result
        function void note_beat(t_in beat);
            logic signed [VALUE_W-1:0] kept[$];
            t_out want;
            int   pos;
            int   removed;
            want.status = ST_DONE;
            if (beat.func == FUNC_INSERT) begin
                inserts++;
                if (held_values.size() >= DEPTH) begin
                    want.status = ST_FULL;
                    dropped++;
                end else begin
                    pos = 0;
                    foreach (held_values[k]) begin
                        if (held_values[k] < beat.value) pos++;
                    end
                    held_values.insert(pos, beat.value);
                end
            end else begin
                deletes++;
                foreach (held_values[k]) begin
                    if (held_values[k] != beat.value) kept.push_back(held_values[k]);
                end
                removed = held_values.size() - kept.size();
                if (removed == 0) missed++;
                if (removed > 1) multi_removed++;
                held_values = kept;
            end
            if (held_values.size() > peak) peak = held_values.size();
            want.entry_count = COUNT_W'(held_values.size());
            owed_results.push_back(want);
        endfunction

        // Compare a result beat with the oldest owed result
        function void check_result(t_out beat);
            t_out want;
            if (owed_results.size() == 0) begin
                $error("unexpected result beat: entry_count=%0d status=%0b",
                       beat.entry_count, beat.status);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            if (beat.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, got %0d",
                       want.entry_count, beat.entry_count);
                errors++;
            end
            if (beat.status !== want.status) begin
                $error("status: expected %0b, got %0b", want.status, beat.status);
                errors++;
            end
        endfunction
    endclass

    logic  clk;
    logic  rst_n      = 1'b0;
    logic  src_valid  = 1'b0;
    t_in   src_data   = '0;
    logic  sink_ready = 1'b0;
    logic  dut_ready;
    logic  dut_valid;
    t_out  dut_data;
    bit    src_burst  = 1'b0;
    int    cycle_count = 0;

    sorted_table_scoreboard board;

    // Values that land on the signed extremes, zero and repeated entries
    logic signed [VALUE_W-1:0] value_pool[8] = '{
        32'sh80000000, 32'sh7FFFFFFF, 32'sd0, -32'sd1,
        32'sd1, -32'sd2, 32'sd42, 32'sh80000001
    };

    sorted_list_insert_delete #(
        .CAPACITY (DEPTH)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (src_valid),
        .o_ready (dut_ready),
        .i_data  (src_data),
        .o_valid (dut_valid),
        .i_ready (sink_ready),
        .o_data  (dut_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watch both channels and hand every completed beat to the scoreboard
    always @(posedge clk) begin
        if (rst_n) begin
            if (src_valid && dut_ready) board.note_beat(src_data);
            if (dut_valid && sink_ready) board.check_result(dut_data);
        end
    end

    // Sink: stall a random number of cycles before each beat, with bursts
    initial begin
        bit sink_burst;
        int stall;
        sink_burst = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if ($urandom_range(0, 29) == 0) sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                sink_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            sink_ready <= 1'b1;
            @(posedge clk);
            while (!dut_valid) @(posedge clk);
        end
    end

    // Stop a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sorted_list_insert_delete_tb failed");
        $finish;
    end

    function automatic int next_gap();
        return src_burst ? 0 : $urandom_range(0, 8);
    endfunction

    // Build one random operation; deletes mostly target a held value
    function automatic t_in draw_op(bit grow);
        t_in op;
        int  roll;
        op.func = ($urandom_range(0, 99) < (grow ? 75 : 30)) ? FUNC_INSERT : FUNC_DELETE;
        roll = $urandom_range(0, 99);
        if (op.func == FUNC_DELETE && roll < 60 && board.held() > 0)
            op.value = board.pick_held();
        else if (roll < 70)
            op.value = value_pool[$urandom_range(0, 7)];
        else
            op.value = $urandom();
        return op;
    endfunction

    // Drive one beat after an optional gap, return once it is taken
    task automatic send_beat(input t_in beat, input int gap);
        if (gap > 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= beat;
        @(posedge clk);
        while (!dut_ready) @(posedge clk);
    endtask

    task automatic send_op(input logic func, input logic signed [VALUE_W-1:0] value);
        t_in op;
        op.func  = func;
        op.value = value;
        send_beat(op, next_gap());
    endtask

    // Hold the source until every owed result has come back
    task automatic wait_drained();
        src_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    initial begin
        bit grow;
        board = new();
        grow  = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty delete, extremes, equal values, miss, full, mass delete
        send_op(FUNC_DELETE, 32'sd5);
        send_op(FUNC_INSERT, 32'sh7FFFFFFF);
        send_op(FUNC_INSERT, 32'sh80000000);
        send_op(FUNC_INSERT, 32'sd0);
        send_op(FUNC_INSERT, -32'sd1);
        send_op(FUNC_INSERT, 32'sd0);
        send_op(FUNC_DELETE, 32'sd12345);
        send_op(FUNC_DELETE, 32'sd0);
        repeat (DEPTH - 3) send_op(FUNC_INSERT, 32'sd42);
        send_op(FUNC_INSERT, 32'sh80000000);
        send_op(FUNC_DELETE, 32'sd42);
        send_op(FUNC_DELETE, 32'sh80000000);
        send_op(FUNC_DELETE, 32'sh7FFFFFFF);
        send_op(FUNC_DELETE, -32'sd1);
        wait_drained();

        // Random: alternate fill and drain phases so the table hits both ends
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 29) == 0) src_burst = !src_burst;
            if (board.held() == 0)
                grow = 1'b1;
            else if (board.held() >= DEPTH && $urandom_range(0, 3) == 0)
                grow = 1'b0;
            else if ($urandom_range(0, 49) == 0)
                grow = !grow;
            send_beat(draw_op(grow), next_gap());
            if (n % 300 == 299) wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d inserts (%0d dropped on a full table), %0d deletes",
                 board.inserts, board.dropped, board.deletes);
        $display("deletes without a match %0d, clearing several entries %0d, peak count %0d",
                 board.missed, board.multi_removed, board.peak);
        if (board.errors == 0)
            $display("sorted_list_insert_delete_tb passed");
        else
            $display("sorted_list_insert_delete_tb failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/sli_pkg.sv
rtl/core/sli_ram.sv
rtl/core/sorted_list_insert_delete.sv
bench/sorted_list_insert_delete_tb.sv
